/* hw/rtl/video_test_pattern_generator_top_defines.svh */
// ----------------------------------------------------------------------------
// Video test pattern generator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VIDEO_TEST_PATTERN_GENERATOR_TOP_DEFINES_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTPG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VTPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/vtpg_pkg.sv */
// ----------------------------------------------------------------------------
// Video test pattern generator package
// Widths, register indexes, reset values and the level-to-byte conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtpg_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRACTION_BITS = 16;
    localparam int LEVEL_BITS    = FRACTION_BITS + 10;
    localparam int STEP_BITS     = FRACTION_BITS + 9;
    localparam int DIM_BITS      = 13;
    localparam int BYTE_BITS     = 8;
    localparam int BAR_BITS      = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = STEP_BITS;

    // Widths used for comparing counters against frame and band sizes.
    localparam int CMP_BITS  = (COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS;
    localparam int BAND_BITS = (COORD_BITS > DIM_BITS + 2) ? COORD_BITS : DIM_BITS + 2;

    localparam logic [COORD_BITS-1:0] COORD_MAX  = '1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = {2'b01, {(LEVEL_BITS - 2){1'b0}}};
    localparam logic [BYTE_BITS-1:0]  BYTE_MAX   = '1;

    localparam logic [BAR_BITS-1:0] BAR_FIRST = 4'd1;
    localparam logic [BAR_BITS-1:0] BAR_WHITE = 4'd8;
    localparam int BAR_RED_BIT   = 0;
    localparam int BAR_BLUE_BIT  = 1;
    localparam int BAR_GREEN_BIT = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH    = 3'd0,
        REG_FRAME_HEIGHT   = 3'd1,
        REG_PATTERN_SELECT = 3'd2,
        REG_BAND_WIDTH     = 3'd3,
        REG_COLUMN_STEP    = 3'd4,
        REG_ROW_STEP       = 3'd5
    } cfg_index_t;

    typedef enum logic {
        PATTERN_GRADIENT = 1'b0,
        PATTERN_BARS     = 1'b1
    } pattern_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]  frame_width;
        logic [DIM_BITS-1:0]  frame_height;
        pattern_t             pattern_select;
        logic [DIM_BITS-1:0]  band_width;
        logic [STEP_BITS-1:0] column_step;
        logic [STEP_BITS-1:0] row_step;
    } vtpg_cfg_t;

    localparam logic [DIM_BITS-1:0]  RST_FRAME_WIDTH  = 13'd1280;
    localparam logic [DIM_BITS-1:0]  RST_FRAME_HEIGHT = 13'd720;
    localparam logic [DIM_BITS-1:0]  RST_BAND_WIDTH   = 13'd182;
    localparam logic [STEP_BITS-1:0] RST_COLUMN_STEP  = 25'd92182;
    localparam logic [STEP_BITS-1:0] RST_ROW_STEP     = 25'd46603;

    // Negative levels show as black, levels of full scale or more as 255.
    function automatic logic [BYTE_BITS-1:0] level_byte(input logic [LEVEL_BITS-1:0] lv);
        logic [BYTE_BITS-1:0] b;
        if (lv[LEVEL_BITS-1]) begin
            b = '0;
        end else if (lv >= LEVEL_FULL) begin
            b = BYTE_MAX;
        end else begin
            b = lv[FRACTION_BITS +: BYTE_BITS];
        end
        return b;
    endfunction

endpackage

/* hw/rtl/video_test_pattern_generator_top.sv */
// ----------------------------------------------------------------------------
// Video test pattern generator
// Raster-order pixel source: four-band gradient or eight color bars.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_        in         tdata[0] restart (1 = new frame at pixel zero)
//  m_        out        tdata red/blue/green bytes, tlast line end, tuser frame end
//  cfg_      in         cfg_index register number, cfg_data value
//
// One pixel per clock sustained while the output is not stalled; each tick is held
// in the input register and then in the result register.
// The per-pixel level update and band compares set the path between them.
// Reset is synchronous on aresetn and returns to pixel zero with default settings.
// With the output stalled, one more item is taken and held in the input register.
`timescale 1ns / 1ps

`include "video_test_pattern_generator_top_defines.svh"

module video_test_pattern_generator_top
    import vtpg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [0] restart, [7:1] zero
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,   // [7:0] red, [15:8] blue, [23:16] green
    output logic                     m_tlast,
    output logic [0:0]               m_tuser,   // [0] frame_end
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    vtpg_cfg_t cfg;

    vtpg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register.
    logic in_valid_reg, in_valid_next;
    logic restart_reg;
    logic advance;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Generator state.
    logic [COORD_BITS-1:0] column_count_reg, column_count_next;
    logic [COORD_BITS-1:0] row_count_reg,    row_count_next;
    logic [LEVEL_BITS-1:0] red_level_reg,    red_level_next;
    logic [LEVEL_BITS-1:0] blue_level_reg,   blue_level_next;
    logic [LEVEL_BITS-1:0] green_level_reg,  green_level_next;
    logic [LEVEL_BITS-1:0] bar_level_reg,    bar_level_next;
    logic [BAR_BITS-1:0]   bar_number_reg,   bar_number_next;

    // Result register.
    logic        m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;
    logic        m_frame_reg, m_frame_next;

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_frame_reg;

    // State as seen by this pixel, after an optional restart.
    logic [COORD_BITS-1:0] col_e, row_e;
    logic [LEVEL_BITS-1:0] red_e, blue_e, green_e, bar_e;
    logic [BAR_BITS-1:0]   barn_e;
    logic [BYTE_BITS-1:0]  red_b, blue_b, green_b, bar_b;
    logic                  last_col, last_row;
    logic [BAND_BITS-1:0]  c_w, bw1, bw2, bw3;
    logic [LEVEL_BITS:0]   bar_sum;
    logic [LEVEL_BITS-1:0] step_l, rstep_l;

    always_comb begin
        col_e   = restart_reg ? '0 : column_count_reg;
        row_e   = restart_reg ? '0 : row_count_reg;
        red_e   = restart_reg ? LEVEL_FULL : red_level_reg;
        blue_e  = restart_reg ? '0 : blue_level_reg;
        green_e = restart_reg ? '0 : green_level_reg;
        bar_e   = restart_reg ? '0 : bar_level_reg;
        barn_e  = restart_reg ? BAR_FIRST : bar_number_reg;

        step_l  = LEVEL_BITS'(cfg.column_step);
        rstep_l = LEVEL_BITS'(cfg.row_step);

        bar_b = level_byte(bar_e);
        if (cfg.pattern_select == PATTERN_GRADIENT) begin
            red_b   = level_byte(red_e);
            blue_b  = level_byte(blue_e);
            green_b = level_byte(green_e);
        end else if (barn_e >= BAR_WHITE) begin
            red_b   = BYTE_MAX;
            blue_b  = BYTE_MAX;
            green_b = BYTE_MAX;
        end else begin
            red_b   = barn_e[BAR_RED_BIT]   ? bar_b : '0;
            blue_b  = barn_e[BAR_BLUE_BIT]  ? bar_b : '0;
            green_b = barn_e[BAR_GREEN_BIT] ? bar_b : '0;
        end

        last_col = (CMP_BITS'(col_e) + CMP_BITS'(1) >= CMP_BITS'(cfg.frame_width))
                   || (col_e == COORD_MAX);
        last_row = (CMP_BITS'(row_e) + CMP_BITS'(1) >= CMP_BITS'(cfg.frame_height))
                   || (row_e == COORD_MAX);

        m_data_next  = {green_b, blue_b, red_b};
        m_last_next  = last_col;
        m_frame_next = last_col && last_row;

        // Four-band gradient.
        c_w = BAND_BITS'(col_e);
        bw1 = BAND_BITS'(cfg.band_width);
        bw2 = bw1 << 1;
        bw3 = bw2 + bw1;
        if (c_w < bw1) begin
            blue_level_next = '0;
            red_level_next  = red_e - step_l;
        end else if (c_w < bw2) begin
            blue_level_next = blue_e + step_l;
            red_level_next  = red_e + step_l;
        end else if (c_w < bw3) begin
            blue_level_next = blue_e - step_l;
            red_level_next  = red_e - step_l;
        end else begin
            blue_level_next = blue_e + step_l;
            red_level_next  = '0;
        end

        // Color bars: a bar ends when its level reaches full scale.
        bar_sum         = {1'b0, bar_e} + (LEVEL_BITS + 1)'(cfg.column_step);
        bar_number_next = barn_e;
        if (bar_sum >= (LEVEL_BITS + 1)'(LEVEL_FULL)) begin
            bar_level_next = '0;
            if (barn_e < BAR_WHITE) begin
                bar_number_next = barn_e + BAR_BITS'(1);
            end
        end else begin
            bar_level_next = bar_sum[LEVEL_BITS-1:0];
        end

        green_level_next  = green_e;
        row_count_next    = row_e;
        column_count_next = col_e + COORD_BITS'(1);
        if (last_col) begin
            column_count_next = '0;
            red_level_next    = LEVEL_FULL;
            blue_level_next   = '0;
            bar_level_next    = '0;
            bar_number_next   = BAR_FIRST;
            if (last_row) begin
                row_count_next   = '0;
                green_level_next = '0;
            end else begin
                if (CMP_BITS'(row_e) < CMP_BITS'(cfg.frame_height >> 1)) begin
                    green_level_next = green_e + rstep_l;
                end else begin
                    green_level_next = green_e - rstep_l;
                end
                row_count_next = row_e + COORD_BITS'(1);
            end
        end

        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            red_level_reg    <= LEVEL_FULL;
            blue_level_reg   <= '0;
            green_level_reg  <= '0;
            bar_level_reg    <= '0;
            bar_number_reg   <= BAR_FIRST;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                red_level_reg    <= red_level_next;
                blue_level_reg   <= blue_level_next;
                green_level_reg  <= green_level_next;
                bar_level_reg    <= bar_level_next;
                bar_number_reg   <= bar_number_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            restart_reg <= s_tdata[0];
        end
        if (advance) begin
            m_data_reg  <= m_data_next;
            m_last_reg  <= m_last_next;
            m_frame_reg <= m_frame_next;
        end
    end

    `VTPG_ASSERT_SAME(a_frame_end_is_line_end, m_tvalid && m_tuser[0], m_tlast,
        "frame end without line end")
    `VTPG_ASSERT_NEXT(a_line_wraps, advance && m_last_next,
        column_count_reg == '0 && bar_number_reg == BAR_FIRST,
        "line end did not return to column zero")
    `VTPG_ASSERT_NEXT(a_frame_wraps, advance && m_frame_next,
        row_count_reg == '0 && green_level_reg == '0,
        "frame end did not return to row zero")
    `VTPG_ASSERT_SAME(a_bar_range, 1'b1,
        bar_number_reg >= BAR_FIRST && bar_number_reg <= BAR_WHITE,
        "bar number out of range")

endmodule

/* hw/rtl/vtpg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Video test pattern generator configuration registers
// Holds the frame, pattern and step settings written over the config channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtpg_cfg_regs
    import vtpg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output vtpg_cfg_t                cfg
);

    vtpg_cfg_t cfg_reg;
    vtpg_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:    cfg_next.frame_width    = cfg_data[DIM_BITS-1:0];
                REG_FRAME_HEIGHT:   cfg_next.frame_height   = cfg_data[DIM_BITS-1:0];
                REG_PATTERN_SELECT: cfg_next.pattern_select = pattern_t'(cfg_data[0]);
                REG_BAND_WIDTH:     cfg_next.band_width     = cfg_data[DIM_BITS-1:0];
                REG_COLUMN_STEP:    cfg_next.column_step    = cfg_data[STEP_BITS-1:0];
                REG_ROW_STEP:       cfg_next.row_step       = cfg_data[STEP_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width    <= RST_FRAME_WIDTH;
            cfg_reg.frame_height   <= RST_FRAME_HEIGHT;
            cfg_reg.pattern_select <= PATTERN_BARS;
            cfg_reg.band_width     <= RST_BAND_WIDTH;
            cfg_reg.column_step    <= RST_COLUMN_STEP;
            cfg_reg.row_step       <= RST_ROW_STEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
